// ===== src/dras_pkg.sv =====
// Shared types and constants for the data ROM port address stepper.
package dras_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned ValW   = 24;
  localparam int unsigned AdjW   = 16;
  localparam int unsigned ModeW  = 7;
  localparam int unsigned BankW  = 2;
  localparam int unsigned RbitsW = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 7;
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 32;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  localparam logic [RbitsW-1:0] RomBitsMin   = 5'd16;
  localparam logic [RbitsW-1:0] RomBitsMax   = 5'd24;
  localparam logic [RbitsW-1:0] RomBitsReset = 5'd24;

  // Bus operation codes.
  localparam logic [OpW-1:0] OP_PORT_READ = 3'd0;
  localparam logic [OpW-1:0] OP_TRIG_A    = 3'd1;
  localparam logic [OpW-1:0] OP_TRIG_B    = 3'd2;
  localparam logic [OpW-1:0] OP_TRIG_C    = 3'd3;
  localparam logic [OpW-1:0] OP_LOAD_OFS  = 3'd4;
  localparam logic [OpW-1:0] OP_LOAD_ADJ  = 3'd5;
  localparam logic [OpW-1:0] OP_LOAD_STR  = 3'd6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_STEP_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BANK_SIZE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROM_BITS  = 2'd2;

  typedef enum logic [2:0] {
    K_NONE,
    K_READ,
    K_TRIG,
    K_LOAD_OFS,
    K_LOAD_ADJ,
    K_LOAD_STR
  } kind_t;

  typedef struct packed {
    logic [ModeW-1:0]  step_mode;
    logic [BankW-1:0]  bank_size_select;
    logic [RbitsW-1:0] rom_address_bits;
  } cfg_t;

  typedef struct packed {
    kind_t            kind;
    logic [ValW-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic            read_valid;
    logic [ValW-1:0] rom_address;
    logic            force_zero;
  } result_t;

endpackage

// ===== src/dras_front.sv =====
// Front end: decodes an incoming bus operation into a command kind.
module dras_front
  import dras_pkg::*;
(
  input  logic [OpW-1:0]   op,
  input  logic [ValW-1:0]  write_value,
  input  logic [ModeW-1:0] step_mode,
  output cmd_t             cmd
);

  logic [1:0] trig_sel;

  assign trig_sel = step_mode[6:5];

  always_comb begin
    cmd.value = write_value;
    case (op)
      OP_PORT_READ: cmd.kind = K_READ;
      OP_TRIG_A, OP_TRIG_B, OP_TRIG_C: begin
        // A trigger only acts when the select field names this trigger.
        cmd.kind = (op[1:0] == trig_sel) ? K_TRIG : K_NONE;
      end
      OP_LOAD_OFS:  cmd.kind = K_LOAD_OFS;
      OP_LOAD_ADJ:  cmd.kind = K_LOAD_ADJ;
      OP_LOAD_STR:  cmd.kind = K_LOAD_STR;
      default:      cmd.kind = K_NONE;
    endcase
  end

endmodule

// ===== src/dras_queue.sv =====
// Two-entry command queue between the front end and the back end.
module dras_queue
  import dras_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t pop_cmd
);

  cmd_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == QCntW'(QDepth));
  assign avail   = (count != '0);
  assign pop_cmd = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/dras_back.sv =====
// Back end: holds the offset, adjust and stride, executes commands and
// registers the ROM address result.
module dras_back
  import dras_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    cmd_avail,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  logic [ValW-1:0]   base_offset;
  logic [AdjW-1:0]   adjust_value;
  logic [AdjW-1:0]   stride_value;
  logic [ValW-1:0]   base_offset_next;
  logic [AdjW-1:0]   adjust_value_next;
  logic [AdjW-1:0]   stride_value_next;

  logic [AdjW-1:0]   stride_raw;
  logic [ValW-1:0]   stride_wide;
  logic [ValW-1:0]   adjust_wide;
  logic [ValW-1:0]   read_adjust;
  logic [ValW-1:0]   read_addr;
  logic [ValW-1:0]   window_mask;
  logic [ValW-1:0]   mirror_mask;
  logic [RbitsW-1:0] rom_bits;
  logic              is_read;
  logic              outside;
  result_t           res_next;

  assign cmd_pop = cmd_avail && (!res_valid || res_ready);

  always_comb begin
    stride_raw  = cfg.step_mode[0] ? stride_value : AdjW'(1);
    stride_wide = {{(ValW-AdjW){cfg.step_mode[2] & stride_raw[AdjW-1]}}, stride_raw};
    adjust_wide = {{(ValW-AdjW){cfg.step_mode[3] & adjust_value[AdjW-1]}}, adjust_value};

    base_offset_next  = base_offset;
    adjust_value_next = adjust_value;
    stride_value_next = stride_value;
    is_read           = 1'b0;

    case (cmd.kind)
      K_READ: begin
        is_read = 1'b1;
        if (cfg.step_mode[4]) begin
          adjust_value_next = adjust_value + stride_raw;
        end else begin
          base_offset_next = base_offset + stride_wide;
        end
      end
      K_TRIG: begin
        is_read          = 1'b1;
        base_offset_next = base_offset + adjust_wide;
      end
      K_LOAD_OFS: base_offset_next  = cmd.value;
      K_LOAD_ADJ: adjust_value_next = cmd.value[AdjW-1:0];
      K_LOAD_STR: stride_value_next = cmd.value[AdjW-1:0];
      default: ;
    endcase

    // The read address uses the adjust after this command's update.
    read_adjust = cfg.step_mode[1]
                ? {{(ValW-AdjW){cfg.step_mode[3] & adjust_value_next[AdjW-1]}},
                   adjust_value_next}
                : '0;
    read_addr = base_offset_next + read_adjust;

    case (cfg.bank_size_select)
      2'd0:    window_mask = 24'h0F_FFFF;
      2'd1:    window_mask = 24'h1F_FFFF;
      2'd2:    window_mask = 24'h3F_FFFF;
      default: window_mask = 24'h7F_FFFF;
    endcase

    if (cfg.rom_address_bits < RomBitsMin) begin
      rom_bits = RomBitsMin;
    end else if (cfg.rom_address_bits > RomBitsMax) begin
      rom_bits = RomBitsMax;
    end else begin
      rom_bits = cfg.rom_address_bits;
    end
    mirror_mask = {ValW{1'b1}} >> (RomBitsMax - rom_bits);

    // Bit 22 falls outside every bank window except the largest one.
    outside = (cfg.bank_size_select != 2'd3) && read_addr[22];

    res_next.read_valid  = is_read;
    res_next.force_zero  = is_read && outside;
    res_next.rom_address = (is_read && !outside)
                         ? (read_addr & window_mask & mirror_mask) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_offset  <= '0;
      adjust_value <= '0;
      stride_value <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (cmd_pop) begin
        base_offset  <= base_offset_next;
        adjust_value <= adjust_value_next;
        stride_value <= stride_value_next;
        res_valid    <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      res <= res_next;
    end
  end

endmodule

// ===== src/data_rom_port_address_stepper.sv =====
// Top level of the data ROM port address stepper.
//
// Each input item on the s_ group is one bus operation: a port read, a hit
// on one of three trigger registers, or a load of the offset, adjust or
// stride register. Every item gives exactly one result item on the m_
// group: a read flag, the mirrored data ROM byte address, and a flag that
// the address lies outside the bank (then the address reads as zero).
// Loads, unused codes and triggers that the mode does not select give an
// all-zero result.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes one of step mode, bank
// size select and ROM address bits per write. The user must write it only while the
// block idles; the block itself does not enforce this. Throughput is one item per
// cycle while the receiver takes results. Each accepted item is decoded into a
// two-entry queue; the back end pops it, executes it and registers its result in
// the output register, from which the result item is offered. When the receiver
// stalls, the result is held in the output register and the queue fills; s_tready
// drops once two items wait.
// Synchronous reset clears the queue, the output valid flag, the offset,
// adjust and stride, and restores the configuration defaults.
module data_rom_port_address_stepper
  import dras_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [InTdataW-1:0]  s_tdata,   // op[2:0], write_value[26:3], zero pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OutTdataW-1:0] m_tdata,   // read_valid[0], rom_address[24:1],
                                          // force_zero[25], zero pad
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDatW-1:0]   cfg_wdata
);

  cfg_t    cfg;
  cmd_t    front_cmd;
  cmd_t    q_cmd;
  logic    q_full;
  logic    q_avail;
  logic    q_pop;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_mode        <= '0;
      cfg.bank_size_select <= '0;
      cfg.rom_address_bits <= RomBitsReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_MODE: cfg.step_mode        <= cfg_wdata[ModeW-1:0];
        CFG_BANK_SIZE: cfg.bank_size_select <= cfg_wdata[BankW-1:0];
        CFG_ROM_BITS:  cfg.rom_address_bits <= cfg_wdata[RbitsW-1:0];
        default: ;
      endcase
    end
  end

  dras_front u_front (
    .op          (s_tdata[OpW-1:0]),
    .write_value (s_tdata[OpW+ValW-1:OpW]),
    .step_mode   (cfg.step_mode),
    .cmd         (front_cmd)
  );

  dras_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (s_tvalid),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_cmd  (q_cmd)
  );

  assign s_tready = !q_full;

  dras_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_avail (q_avail),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {{(OutTdataW-ValW-2){1'b0}}, res.force_zero, res.rom_address,
                    res.read_valid};

endmodule

// ===== src/dras_checker.sv =====
// Port-level checks for the data ROM port address stepper, bound to the top.
module dras_checker
  import dras_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OutTdataW-1:0] m_tdata
);

  // No result can be pending in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // An out-of-bank read must carry a zero address.
  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[25] |-> m_tdata[0] && (m_tdata[24:1] == '0))
    else $error("force_zero result with nonzero address or no read");

  // Items that issue no read give an all-zero result.
  a_no_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata == '0))
    else $error("non-read result is not zero");

  // The bank window never reaches address bit 23.
  a_window: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[24] && (m_tdata[OutTdataW-1:26] == '0))
    else $error("address beyond the largest window or padding set");

endmodule

bind data_rom_port_address_stepper dras_checker u_dras_checker (.*);

// ===== dv/dras_result_checker.sv =====
// Checker that predicts and compares the data ROM port address stepper's result items.
module dras_result_checker
  import dras_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [InTdataW-1:0]  s_tdata,   // op[2:0], write_value[26:3], zero pad
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [OutTdataW-1:0] m_tdata,   // read_valid[0], rom_address[24:1],
                                          // force_zero[25], zero pad
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDatW-1:0]   cfg_wdata,
  output int                   mismatch_count,
  output int                   results_pending
);

  localparam int unsigned ModeStrideEn = 0;
  localparam int unsigned ModeAdjustEn = 1;
  localparam int unsigned ModeStrideSx = 2;
  localparam int unsigned ModeAdjustSx = 3;
  localparam int unsigned ModeStepAdj  = 4;
  localparam int unsigned BankBit      = 22;
  localparam logic [BankW-1:0] BankFull = 2'd3;
  localparam logic [31:0] MbUnit = 32'h10_0000;

  logic [ModeW-1:0]  mode_q;
  logic [BankW-1:0]  bank_q;
  logic [RbitsW-1:0] rbits_q;
  logic [ValW-1:0]   offset_q;
  logic [AdjW-1:0]   adjust_q;
  logic [AdjW-1:0]   stride_q;

  result_t expected_results[$];

  function automatic logic [ValW-1:0] widen(input logic [AdjW-1:0] v, input logic sx);
    return sx ? {{(ValW-AdjW){v[AdjW-1]}}, v} : {{(ValW-AdjW){1'b0}}, v};
  endfunction

  // Windows the address to the bank, then mirrors it to the physical ROM size.
  function automatic result_t rom_lookup(input logic [ValW-1:0] addr);
    result_t r;
    logic [31:0] window;
    logic [31:0] mirror;
    logic [RbitsW-1:0] nbits;
    r.read_valid  = 1'b1;
    r.rom_address = '0;
    r.force_zero  = 1'b0;
    if (bank_q != BankFull && addr[BankBit]) begin
      r.force_zero = 1'b1;
      return r;
    end
    nbits = rbits_q;
    if (nbits < RomBitsMin) nbits = RomBitsMin;
    if (nbits > RomBitsMax) nbits = RomBitsMax;
    window = (MbUnit << bank_q) - 32'd1;
    mirror = (32'd1 << nbits) - 32'd1;
    r.rom_address = ValW'({8'd0, addr} & window & mirror);
    return r;
  endfunction

  function automatic result_t port_lookup();
    logic [ValW-1:0] adj;
    adj = mode_q[ModeAdjustEn] ? widen(adjust_q, mode_q[ModeAdjustSx]) : '0;
    return rom_lookup(offset_q + adj);
  endfunction

  // Updates the offset, adjust and stride for one bus operation and returns its result.
  function automatic result_t apply_bus_op(input logic [OpW-1:0] op,
                                           input logic [ValW-1:0] wv);
    result_t r;
    logic [ValW-1:0] stride;
    r = '0;
    case (op)
      OP_PORT_READ: begin
        stride = widen(mode_q[ModeStrideEn] ? stride_q : AdjW'(1), mode_q[ModeStrideSx]);
        if (mode_q[ModeStepAdj]) adjust_q = adjust_q + stride[AdjW-1:0];
        else offset_q = offset_q + stride;
        r = port_lookup();
      end
      OP_TRIG_A, OP_TRIG_B, OP_TRIG_C: begin
        if (mode_q[6:5] == op[1:0]) begin
          offset_q = offset_q + widen(adjust_q, mode_q[ModeAdjustSx]);
          r = port_lookup();
        end
      end
      OP_LOAD_OFS: offset_q = wv;
      OP_LOAD_ADJ: adjust_q = wv[AdjW-1:0];
      OP_LOAD_STR: stride_q = wv[AdjW-1:0];
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      mode_q         = '0;
      bank_q         = '0;
      rbits_q        = RomBitsReset;
      offset_q       = '0;
      adjust_q       = '0;
      stride_q       = '0;
      mismatch_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_MODE: mode_q  = cfg_wdata[ModeW-1:0];
          CFG_BANK_SIZE: bank_q  = cfg_wdata[BankW-1:0];
          CFG_ROM_BITS:  rbits_q = cfg_wdata[RbitsW-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.read_valid  = m_tdata[0];
        got.rom_address = m_tdata[ValW:1];
        got.force_zero  = m_tdata[ValW+1];
        if (expected_results.size() == 0) begin
          $display("%0t: result item with none expected: got rv=%0b addr=%06h fz=%0b",
                   $time, got.read_valid, got.rom_address, got.force_zero);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.read_valid !== want.read_valid) begin
            $display("%0t: read_valid expected %0b got %0b",
                     $time, want.read_valid, got.read_valid);
            mismatch_count++;
          end
          if (got.rom_address !== want.rom_address) begin
            $display("%0t: rom_address expected %06h got %06h",
                     $time, want.rom_address, got.rom_address);
            mismatch_count++;
          end
          if (got.force_zero !== want.force_zero) begin
            $display("%0t: force_zero expected %0b got %0b",
                     $time, want.force_zero, got.force_zero);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_bus_op(s_tdata[OpW-1:0], s_tdata[OpW +: ValW]));
    end
    results_pending <= expected_results.size();
  end

endmodule

// ===== dv/tb_data_rom_port_address_stepper.sv =====
// Testbench top for the data ROM port address stepper: stimulus, handshakes and verdict.
module tb_data_rom_port_address_stepper;
  import dras_pkg::*;

  localparam logic [OpW-1:0]     OP_UNUSED  = 3'd7;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned RandPhases    = 10;
  localparam int unsigned ItemsPerPhase = 50;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [InTdataW-1:0]  s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OutTdataW-1:0] m_tdata;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [CfgDatW-1:0]   cfg_wdata;

  int mismatch_count;
  int results_pending;

  logic             tx_fast;
  logic             rx_fast;
  logic [ModeW-1:0] cur_mode;

  data_rom_port_address_stepper u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  dras_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // Sends one bus operation after a random gap; valid stays high after acceptance until
  // the next falling edge, where the next item or a drain takes over.
  task automatic send_op(input logic [OpW-1:0] op, input logic [ValW-1:0] wv);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) tx_fast = ~tx_fast;
    gap = tx_fast ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InTdataW-OpW-ValW){1'b0}}, wv, op};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Registers are only written once every expected result has come back.
  task automatic set_config(input logic [CfgDatW-1:0] mode, input logic [CfgDatW-1:0] bank,
                            input logic [CfgDatW-1:0] rbits);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STEP_MODE;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_index <= CFG_BANK_SIZE;
    cfg_wdata <= bank;
    @(negedge clk);
    cfg_index <= CFG_ROM_BITS;
    cfg_wdata <= rbits;
    @(negedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= CfgDatW'($urandom_range(0, 127));
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_mode = mode[ModeW-1:0];
  endtask

  function automatic logic [ValW-1:0] pick_value();
    logic [ValW-1:0] edges[4];
    edges[0] = 24'h3F_FFF8;
    edges[1] = 24'hFF_FFF8;
    edges[2] = 24'h7F_FFF8;
    edges[3] = 24'h00_FFF8;
    // A quarter of the values sit near the bank bit, bit 23, the 24-bit wrap or the 16-bit sign.
    if ($urandom_range(0, 3) == 0)
      return edges[$urandom_range(0, 3)] + ValW'($urandom_range(0, 15));
    return ValW'($urandom);
  endfunction

  function automatic logic [OpW-1:0] pick_trigger();
    case ($urandom_range(0, 2))
      0: return OP_TRIG_A;
      1: return OP_TRIG_B;
      default: return OP_TRIG_C;
    endcase
  endfunction

  task automatic send_random_op();
    int unsigned pick;
    logic [OpW-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = OP_PORT_READ;
    else if (pick < 52) op = (cur_mode[6:5] == 2'd0) ? pick_trigger() : OpW'(cur_mode[6:5]);
    else if (pick < 60) op = pick_trigger();
    else if (pick < 72) op = OP_LOAD_OFS;
    else if (pick < 82) op = OP_LOAD_ADJ;
    else if (pick < 93) op = OP_LOAD_STR;
    else op = OP_UNUSED;
    send_op(op, pick_value());
  endtask

  function automatic logic [CfgDatW-1:0] pick_rom_bits();
    logic [CfgDatW-1:0] v;
    v = CfgDatW'($urandom_range(0, 127));
    case ($urandom_range(0, 4))
      0: v[RbitsW-1:0] = RomBitsMin;
      1: v[RbitsW-1:0] = RomBitsMax;
      2: v[RbitsW-1:0] = '0;
      3: v[RbitsW-1:0] = '1;
      default: ;
    endcase
    return v;
  endfunction

  // The receiver draws a stall for every result item, with stretches of none.
  initial begin
    int unsigned stall;
    rx_fast = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_fast = ~rx_fast;
      stall = rx_fast ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned mode_pick;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    tx_fast   = 1'b0;
    cur_mode  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset configuration: unit stride, no adjust, no trigger enabled.
    send_op(OP_PORT_READ, 24'h00_0000);
    send_op(OP_LOAD_OFS, 24'hFF_FFFF);
    send_op(OP_PORT_READ, 24'hFF_FFFF);
    send_op(OP_LOAD_OFS, 24'h3F_FFFF);
    send_op(OP_PORT_READ, 24'h00_0000);
    send_op(OP_LOAD_ADJ, 24'hFF_FFFF);
    send_op(OP_LOAD_STR, 24'hFF_FFFF);
    send_op(OP_TRIG_A, 24'h00_0000);
    send_op(OP_TRIG_B, 24'hAA_AAAA);
    send_op(OP_TRIG_C, 24'h55_5555);
    send_op(OP_UNUSED, 24'hFF_FFFF);
    send_op(OP_PORT_READ, 24'h00_0000);

    // Every mode bit set, full 8 MB window, smallest ROM.
    set_config(7'h7F, 7'h03, 7'h10);
    send_op(OP_PORT_READ, 24'h00_0000);
    send_op(OP_PORT_READ, 24'h00_0000);
    send_op(OP_TRIG_C, 24'h00_0000);
    send_op(OP_TRIG_A, 24'h00_0000);
    send_op(OP_LOAD_OFS, 24'h7F_FFFF);
    send_op(OP_PORT_READ, 24'h00_0000);

    // Trigger A, then trigger B selected, offset stepping; ROM bits above and below the valid range.
    set_config(7'b0101111, 7'h02, 7'h1F);
    send_op(OP_TRIG_A, 24'h00_0000);
    send_op(OP_PORT_READ, 24'h00_0000);
    send_op(OP_TRIG_B, 24'h00_0000);
    set_config(7'b1000001, 7'h01, 7'h00);
    send_op(OP_LOAD_OFS, 24'h1F_FFF0);
    send_op(OP_TRIG_B, 24'h00_0000);
    send_op(OP_PORT_READ, 24'h00_0000);

    for (int unsigned p = 0; p < RandPhases; p++) begin
      mode_pick = $urandom_range(0, 9);
      set_config(mode_pick == 0 ? 7'h00 : mode_pick == 1 ? 7'h7F : CfgDatW'($urandom_range(0, 127)),
                 CfgDatW'($urandom_range(0, 127)), pick_rom_bits());
      for (int unsigned i = 0; i < ItemsPerPhase; i++) send_random_op();
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
